/* rtl/pdrc_pkg.sv */
// Shared types, constants and helpers of the PCM depth and rate converter.
`timescale 1ns / 1ps
`default_nettype none
package pdrc_pkg;

  localparam int NUM_CH      = 4;
  localparam int SAMPLE_W    = 32;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = SAMPLE_W / BYTE_W;
  localparam int RATE_W      = 24;
  localparam int PHASE_W     = RATE_W + 1;
  localparam int BITS_W      = 6;
  localparam int CC_W        = 3;
  localparam int DEPTH_W     = 3;
  localparam int MAX_REPEATS = 64;
  localparam int REP_W       = $clog2(MAX_REPEATS);
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // Register indexes; the byte address is four times the index.
  localparam logic [REG_IDX_W-1:0] REG_IN_BITS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_BITS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IN_RATE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_RATE = 3'd4;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] frame_t;

  typedef struct packed {
    frame_t ch;
    logic   last;
  } entry_t;

  typedef struct packed {
    frame_t ch;
    logic   run_end;
    logic   clipped;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] dvd;
    logic [RATE_W-1:0]  dsr;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] rem;
  } mod_rsp_t;

  // Bit count rounded up to whole bytes, kept between one byte and the sample width.
  function automatic logic [DEPTH_W-1:0] byte_depth(input logic [BITS_W-1:0] bits);
    logic [DEPTH_W:0] d;
    d = {1'b0, bits[BITS_W-1:3]} + {{DEPTH_W{1'b0}}, |bits[2:0]};
    if (d == '0) begin
      d = (DEPTH_W+1)'(1);
    end
    if (d > (DEPTH_W+1)'(MAX_BYTES)) begin
      d = (DEPTH_W+1)'(MAX_BYTES);
    end
    return d[DEPTH_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/pcm_depth_and_rate_converter.sv */
// Top level: configuration registers, front end, queue, remainder unit and back end.
// The back end pops the queue head in its idle state, then passes a check state and a plan
// state before it makes its results, if any, and holds a result while the output stalls;
// it takes no new request until it is idle again. A stale phase after a rate change, or
// the first upsampling request after one, adds a pass through the remainder unit.
// Synchronous active-low reset restores register defaults and clears queue, held frame, phase.
`timescale 1ns / 1ps
`default_nettype none
module pcm_depth_and_rate_converter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_a,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_b,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_c,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_d,
  input  wire logic                          in_last_frame,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pdrc_pkg::SAMPLE_W-1:0]      out_a,
  output logic [pdrc_pkg::SAMPLE_W-1:0]      out_b,
  output logic [pdrc_pkg::SAMPLE_W-1:0]      out_c,
  output logic [pdrc_pkg::SAMPLE_W-1:0]      out_d,
  output logic                               out_run_end,
  output logic                               out_repeat_clipped,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdrc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pdrc_pkg::DATA_W-1:0]   pwdata,
  output logic [pdrc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import pdrc_pkg::*;

  logic [BITS_W-1:0]    in_bits_r;
  logic [BITS_W-1:0]    out_bits_r;
  logic [CC_W-1:0]      chan_cnt_r;
  logic [RATE_W-1:0]    in_rate_r;
  logic [RATE_W-1:0]    out_rate_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [RATE_W-1:0]    ir;
  logic [RATE_W-1:0]    orr;

  frame_t   smp;
  entry_t   front_entry;
  entry_t   q_head;
  logic     push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  result_t  res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // A rate of zero runs as a rate of one.
  assign ir  = (in_rate_r == '0) ? RATE_W'(1) : in_rate_r;
  assign orr = (out_rate_r == '0) ? RATE_W'(1) : out_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r  <= BITS_W'(16);
      out_bits_r <= BITS_W'(16);
      chan_cnt_r <= CC_W'(2);
      in_rate_r  <= RATE_W'(48000);
      out_rate_r <= RATE_W'(48000);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IN_BITS:  in_bits_r  <= pwdata[BITS_W-1:0];
        REG_OUT_BITS: out_bits_r <= pwdata[BITS_W-1:0];
        REG_CHANNELS: chan_cnt_r <= pwdata[CC_W-1:0];
        REG_IN_RATE:  in_rate_r  <= pwdata[RATE_W-1:0];
        REG_OUT_RATE: out_rate_r <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_BITS:  prdata = DATA_W'(in_bits_r);
      REG_OUT_BITS: prdata = DATA_W'(out_bits_r);
      REG_CHANNELS: prdata = DATA_W'(chan_cnt_r);
      REG_IN_RATE:  prdata = DATA_W'(in_rate_r);
      REG_OUT_RATE: prdata = DATA_W'(out_rate_r);
      default:      prdata = '0;
    endcase
  end

  assign smp[0]   = in_sample_a;
  assign smp[1]   = in_sample_b;
  assign smp[2]   = in_sample_c;
  assign smp[3]   = in_sample_d;
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  pdrc_front u_front (
    .smp      (smp),
    .last     (in_last_frame),
    .in_bits  (in_bits_r),
    .out_bits (out_bits_r),
    .chan_cnt (chan_cnt_r),
    .entry    (front_entry)
  );

  pdrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdrc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  pdrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ir        (ir),
    .orr       (orr),
    .cfg_wr    (cfg_wr),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_a              = res.ch[0];
  assign out_b              = res.ch[1];
  assign out_c              = res.ch[2];
  assign out_d              = res.ch[3];
  assign out_run_end        = res.run_end;
  assign out_repeat_clipped = res.clipped;

  // An accepted request is in the queue on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) push |=> !q_empty)
    else $error("queue empty right after an accepted request");

  // The back end never restarts the remainder unit while it is still iterating.
  assert property (@(posedge clk) disable iff (!rst_n) mod_req.start |-> !mod_rsp.busy)
    else $error("remainder unit restarted while busy");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

/* rtl/pdrc_front.sv */
// Front end: cuts each channel sample to the output byte depth and gates unused channels.
`timescale 1ns / 1ps
`default_nettype none
module pdrc_front (
  input  wire pdrc_pkg::frame_t              smp,
  input  wire logic                          last,
  input  wire logic [pdrc_pkg::BITS_W-1:0]   in_bits,
  input  wire logic [pdrc_pkg::BITS_W-1:0]   out_bits,
  input  wire logic [pdrc_pkg::CC_W-1:0]     chan_cnt,
  output pdrc_pkg::entry_t                   entry
);
  import pdrc_pkg::*;

  logic [DEPTH_W-1:0]  di;
  logic [DEPTH_W-1:0]  dout;
  logic [DEPTH_W-1:0]  drop;
  logic [CC_W-1:0]     chans;
  logic [SAMPLE_W-1:0] mask;
  logic [4:0]          shamt;

  always_comb begin
    di   = byte_depth(in_bits);
    dout = byte_depth(out_bits);
    if (dout > di) begin
      dout = di;
    end
    drop  = di - dout;
    shamt = {drop[1:0], 3'b000};
    if (chan_cnt == '0) begin
      chans = CC_W'(1);
    end else if (chan_cnt > CC_W'(NUM_CH)) begin
      chans = CC_W'(NUM_CH);
    end else begin
      chans = chan_cnt;
    end
    for (int b = 0; b < MAX_BYTES; b++) begin
      mask[b*BYTE_W +: BYTE_W] = (DEPTH_W'(b) < di) ? '1 : '0;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      entry.ch[c] = (CC_W'(c) < chans) ? ((smp[c] & mask) >> shamt) : '0;
    end
    entry.last = last;
  end

endmodule
`default_nettype wire

/* rtl/pdrc_queue.sv */
// Small request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module pdrc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire pdrc_pkg::entry_t push_data,
  input  wire logic             pop,
  output pdrc_pkg::entry_t      head,
  output logic                  full,
  output logic                  empty
);
  import pdrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/pdrc_mod.sv */
// Restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdrc_mod (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pdrc_pkg::mod_req_t req,
  output pdrc_pkg::mod_rsp_t      rsp
);
  import pdrc_pkg::*;

  localparam int CNT_W = $clog2(PHASE_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PHASE_W-1:0] dvd_r;
  logic [RATE_W-1:0]  dsr_r;
  logic [RATE_W-1:0]  rem_r;
  logic [RATE_W:0]    trial;
  logic [RATE_W:0]    diff;

  assign trial = {rem_r, dvd_r[PHASE_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dvd;
      dsr_r <= req.dsr;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      // The partial remainder stays below the divisor, so the top bit drops.
      rem_r <= (trial >= {1'b0, dsr_r}) ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PHASE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/pdrc_back.sv */
// Back end: phase accumulator, repeat and hold sequencer, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module pdrc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire pdrc_pkg::entry_t            q_head,
  output logic                             q_pop,
  input  wire logic [pdrc_pkg::RATE_W-1:0] ir,
  input  wire logic [pdrc_pkg::RATE_W-1:0] orr,
  input  wire logic                        cfg_wr,
  output pdrc_pkg::mod_req_t               mod_req,
  input  wire pdrc_pkg::mod_rsp_t          mod_rsp,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pdrc_pkg::result_t                res
);
  import pdrc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_OM   = 3'd3;
  localparam logic [2:0] S_PLAN = 3'd4;
  localparam logic [2:0] S_UP   = 3'd5;
  localparam logic [2:0] S_DN1  = 3'd6;
  localparam logic [2:0] S_DN2  = 3'd7;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  entry_t             cur_r;
  frame_t             held_r;
  logic               held_valid_r;
  logic [PHASE_W-1:0] phase_r;
  logic [RATE_W-1:0]  acc_r;
  logic [RATE_W-1:0]  om_r;
  logic               om_ok_r;
  logic [RATE_W-1:0]  limit_r;
  logic [RATE_W-1:0]  rep_acc_r;
  logic [REP_W-1:0]   rep_cnt_r;
  logic               clip_r;
  logic               emit_a_r;
  logic               out_valid_r;
  result_t            res_r;

  logic               up;
  logic               slot;
  logic               stale;
  logic [RATE_W-1:0]  lim_w;
  logic [30:0]        clip_sum;
  logic               clip_w;
  logic [RATE_W-1:0]  up_phase;
  logic [RATE_W:0]    dn_sum;
  logic [RATE_W-1:0]  dn_acc;
  logic [RATE_W:0]    rep_nxt;
  logic               rep_done;
  logic               flush;
  logic               emit;

  assign up    = (orr >= ir);
  assign slot  = !out_valid_r || out_ready;
  assign stale = (phase_r >= {1'b0, ir});
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    lim_w    = cur_r.last ? (orr - ir) : (orr - RATE_W'(1));
    // More than 64 repeats exactly when acc + 64*ir still lies within the limit.
    clip_sum = {7'd0, acc_r} + {1'b0, ir, 6'd0};
    clip_w   = (clip_sum <= {7'd0, lim_w});
    // Next phase after a full upsampling run: (acc - out_rate) mod in_rate.
    up_phase = (acc_r >= om_r) ? (acc_r - om_r) : (acc_r + ir - om_r);
    dn_sum   = {1'b0, acc_r} + {1'b0, orr};
    dn_acc   = (dn_sum >= {1'b0, ir}) ? dn_sum[RATE_W-1:0] - ir : dn_sum[RATE_W-1:0];
    rep_nxt  = {1'b0, rep_acc_r} + {1'b0, ir};
    rep_done = (rep_nxt > {1'b0, limit_r}) || (rep_cnt_r == REP_W'(MAX_REPEATS - 1));
    flush    = cur_r.last && (acc_r < orr);
    emit     = slot && ((state_r == S_UP) || ((state_r == S_DN1) && emit_a_r) ||
                        (state_r == S_DN2));
  end

  always_comb begin
    mod_req.start = 1'b0;
    mod_req.dvd   = phase_r;
    mod_req.dsr   = ir;
    if (q_pop && stale) begin
      mod_req.start = 1'b1;
    end else if ((state_r == S_CHK) && up && !om_ok_r) begin
      mod_req.start = 1'b1;
      mod_req.dvd   = {1'b0, orr};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = stale ? S_RED : S_CHK;
        end
      end
      S_RED: begin
        if (mod_rsp.done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = (up && !om_ok_r) ? S_OM : S_PLAN;
      end
      S_OM: begin
        if (mod_rsp.done) begin
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        if (!up) begin
          state_nxt = S_DN1;
        end else if (acc_r <= lim_w) begin
          state_nxt = S_UP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UP: begin
        if (slot && rep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_DN1: begin
        if (!emit_a_r || slot) begin
          state_nxt = flush ? S_DN2 : S_IDLE;
        end
      end
      S_DN2: begin
        if (slot) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_valid_r <= 1'b0;
      phase_r      <= '0;
      om_ok_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        om_ok_r <= 1'b0;
      end else if ((state_r == S_OM) && mod_rsp.done) begin
        om_ok_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r <= q_head;
            acc_r <= phase_r[RATE_W-1:0];
          end
        end
        S_RED: begin
          if (mod_rsp.done) begin
            acc_r <= mod_rsp.rem;
          end
        end
        S_CHK: begin
        end
        S_OM: begin
          if (mod_rsp.done) begin
            om_r <= mod_rsp.rem;
          end
        end
        S_PLAN: begin
          if (up) begin
            held_valid_r <= 1'b0;
            limit_r      <= lim_w;
            rep_acc_r    <= acc_r;
            rep_cnt_r    <= '0;
            clip_r       <= clip_w;
            if (acc_r > lim_w) begin
              phase_r <= cur_r.last ? '0 : {1'b0, up_phase};
            end
          end else begin
            acc_r    <= dn_acc;
            emit_a_r <= held_valid_r && (acc_r < orr);
          end
        end
        S_UP: begin
          if (slot) begin
            res_r.ch      <= cur_r.ch;
            res_r.run_end <= rep_done;
            res_r.clipped <= clip_r;
            rep_acc_r     <= rep_nxt[RATE_W-1:0];
            rep_cnt_r     <= rep_cnt_r + REP_W'(1);
            if (rep_done) begin
              phase_r <= cur_r.last ? '0 : {1'b0, up_phase};
            end
          end
        end
        S_DN1: begin
          if (!emit_a_r || slot) begin
            if (emit_a_r) begin
              res_r.ch      <= held_r;
              res_r.run_end <= !flush;
              res_r.clipped <= 1'b0;
            end
            held_r       <= cur_r.ch;
            held_valid_r <= !cur_r.last;
            phase_r      <= cur_r.last ? '0 : {1'b0, acc_r};
          end
        end
        S_DN2: begin
          if (slot) begin
            res_r.ch      <= cur_r.ch;
            res_r.run_end <= 1'b1;
            res_r.clipped <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* sim/pcm_depth_and_rate_converter_checker.sv */
// Checker for the PCM depth and rate converter: tracks registers, predicts and compares frames.
`timescale 1ns / 1ps
module pcm_depth_and_rate_converter_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_a,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_b,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_c,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] in_sample_d,
  input  wire logic                          in_last_frame,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] out_a,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] out_b,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] out_c,
  input  wire logic [pdrc_pkg::SAMPLE_W-1:0] out_d,
  input  wire logic                          out_run_end,
  input  wire logic                          out_repeat_clipped,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic                          pready,
  input  wire logic [pdrc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pdrc_pkg::DATA_W-1:0]   pwdata,
  output int                                 fail_count,
  output int                                 pending_results,
  output int                                 results_checked
);
  import pdrc_pkg::*;

  logic [BITS_W-1:0] in_bits_q;
  logic [BITS_W-1:0] out_bits_q;
  logic [CC_W-1:0]   chans_q;
  logic [RATE_W-1:0] in_rate_q;
  logic [RATE_W-1:0] out_rate_q;

  frame_t             held_frame;
  logic               held_valid;
  logic [PHASE_W-1:0] phase_acc;

  result_t converted_q[$];
  int      failures;
  int      checked;

  initial begin
    fail_count = 0;
    pending_results = 0;
    results_checked = 0;
    failures = 0;
    checked = 0;
  end

  function automatic int unsigned byte_count(input logic [BITS_W-1:0] bits);
    int unsigned d;
    d = (int'(bits) + 7) / 8;
    if (d < 1) d = 1;
    if (d > MAX_BYTES) d = MAX_BYTES;
    return d;
  endfunction

  function automatic longint unsigned nonzero_rate(input logic [RATE_W-1:0] rate);
    return (rate == '0) ? 64'd1 : 64'(rate);
  endfunction

  // Works out the output frames that one input frame causes and queues them.
  task automatic convert_frame(input frame_t raw, input logic last);
    int unsigned       di;
    int unsigned       dout;
    int unsigned       chans;
    longint unsigned   ir;
    longint unsigned   orr;
    longint unsigned   acc;
    longint unsigned   limit;
    longint unsigned   count;
    longint unsigned   reps;
    longint unsigned   keep_mask;
    frame_t            cut;
    logic              clipped;
    logic              emit_held;
    logic              emit_tail;
    result_t           r;
    di = byte_count(in_bits_q);
    dout = byte_count(out_bits_q);
    if (dout > di) dout = di;
    chans = (chans_q == '0) ? 1 : ((chans_q > NUM_CH) ? NUM_CH : chans_q);
    ir = nonzero_rate(in_rate_q);
    orr = nonzero_rate(out_rate_q);
    keep_mask = (64'd1 << (8 * di)) - 64'd1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (c < chans) begin
        cut[c] = SAMPLE_W'((64'(raw[c]) & keep_mask) >> (8 * (di - dout)));
      end else begin
        cut[c] = '0;
      end
    end
    acc = 64'(phase_acc) % ir;

    if (orr >= ir) begin
      // Upsampling: a frame still held from downsampling is dropped here.
      held_valid = 1'b0;
      limit = last ? orr - ir : orr - 64'd1;
      count = (acc <= limit) ? (limit - acc) / ir + 64'd1 : 64'd0;
      clipped = (count > MAX_REPEATS);
      reps = clipped ? 64'(MAX_REPEATS) : count;
      for (longint unsigned t = 0; t < reps; t++) begin
        r.ch = cut;
        r.run_end = (t == reps - 1);
        r.clipped = clipped;
        converted_q.push_back(r);
      end
      phase_acc = last ? '0 : PHASE_W'(acc + count * ir - orr);
    end else begin
      emit_held = held_valid && (acc < orr);
      acc = acc + orr;
      if (acc >= ir) acc = acc - ir;
      emit_tail = last && (acc < orr);
      if (emit_held) begin
        r.ch = held_frame;
        r.run_end = !emit_tail;
        r.clipped = 1'b0;
        converted_q.push_back(r);
      end
      held_frame = cut;
      held_valid = 1'b1;
      phase_acc = PHASE_W'(acc);
      if (emit_tail) begin
        r.ch = cut;
        r.run_end = 1'b1;
        r.clipped = 1'b0;
        converted_q.push_back(r);
      end
      if (last) begin
        held_valid = 1'b0;
        phase_acc = '0;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_t  got;
    result_t want;
    if (!rst_n) begin
      in_bits_q  = 6'd16;
      out_bits_q = 6'd16;
      chans_q    = 3'd2;
      in_rate_q  = 24'd48000;
      out_rate_q = 24'd48000;
      held_frame = '0;
      held_valid = 1'b0;
      phase_acc  = '0;
      converted_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_IN_BITS:  in_bits_q  = pwdata[BITS_W-1:0];
          REG_OUT_BITS: out_bits_q = pwdata[BITS_W-1:0];
          REG_CHANNELS: chans_q    = pwdata[CC_W-1:0];
          REG_IN_RATE:  in_rate_q  = pwdata[RATE_W-1:0];
          REG_OUT_RATE: out_rate_q = pwdata[RATE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = {out_d, out_c, out_b, out_a};
        if (converted_q.size() == 0) begin
          failures++;
          $display("%0t ns: output frame with none expected, expected nothing, got %h %h %h %h",
                   $time, out_a, out_b, out_c, out_d);
        end else begin
          want = converted_q.pop_front();
          checked++;
          for (int c = 0; c < NUM_CH; c++) begin
            check_field($sformatf("channel %0d", c), want.ch[c], got[c]);
          end
          check_field("run_end", 32'(want.run_end), 32'(out_run_end));
          check_field("repeat_clipped", 32'(want.clipped), 32'(out_repeat_clipped));
        end
      end

      if (in_valid && in_ready) begin
        convert_frame({in_sample_d, in_sample_c, in_sample_b, in_sample_a}, in_last_frame);
      end
    end
    fail_count <= failures;
    pending_results <= converted_q.size();
    results_checked <= checked;
  end

endmodule

/* sim/pcm_depth_and_rate_converter_tb.sv */
// Testbench top for the PCM depth and rate converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module pcm_depth_and_rate_converter_tb;
  import pdrc_pkg::*;

  localparam int RANDOM_ITEMS    = 180;
  localparam int SETTLE_CYCLES   = 128;
  localparam int WATCHDOG_CYCLES = 3000;

  typedef struct {
    logic [BITS_W-1:0] in_bits;
    logic [BITS_W-1:0] out_bits;
    logic [CC_W-1:0]   chans;
    logic [RATE_W-1:0] in_rate;
    logic [RATE_W-1:0] out_rate;
  } conv_setting_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample_a;
  logic [SAMPLE_W-1:0] in_sample_b;
  logic [SAMPLE_W-1:0] in_sample_c;
  logic [SAMPLE_W-1:0] in_sample_d;
  logic                in_last_frame;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_a;
  logic [SAMPLE_W-1:0] out_b;
  logic [SAMPLE_W-1:0] out_c;
  logic [SAMPLE_W-1:0] out_d;
  logic                out_run_end;
  logic                out_repeat_clipped;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_count;
  int pending_results;
  int results_checked;

  int frames_sent = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  pcm_depth_and_rate_converter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_a(in_sample_a), .in_sample_b(in_sample_b),
    .in_sample_c(in_sample_c), .in_sample_d(in_sample_d),
    .in_last_frame(in_last_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d),
    .out_run_end(out_run_end), .out_repeat_clipped(out_repeat_clipped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pcm_depth_and_rate_converter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_a(in_sample_a), .in_sample_b(in_sample_b),
    .in_sample_c(in_sample_c), .in_sample_d(in_sample_d),
    .in_last_frame(in_last_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d),
    .out_run_end(out_run_end), .out_repeat_clipped(out_repeat_clipped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending_results(pending_results),
    .results_checked(results_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly no gap, sometimes a short gap, rarely a long pause.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run if no request of any kind is taken for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("%0t ns: no request taken for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic conv_setting_t make_setting(input int ib, input int ob, input int ch,
                                                 input int ir, input int orr);
    conv_setting_t s;
    s.in_bits  = BITS_W'(ib);
    s.out_bits = BITS_W'(ob);
    s.chans    = CC_W'(ch);
    s.in_rate  = RATE_W'(ir);
    s.out_rate = RATE_W'(orr);
    return s;
  endfunction

  function automatic logic [RATE_W-1:0] edge_rate();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return RATE_W'(1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] random_bits();
    if ($urandom_range(0, 9) == 0) begin
      return ($urandom_range(0, 1) == 0) ? '0 : BITS_W'($urandom_range(33, 63));
    end
    return BITS_W'($urandom_range(1, 32));
  endfunction

  function automatic conv_setting_t random_setting();
    conv_setting_t s;
    s.in_bits = random_bits();
    s.out_bits = random_bits();
    s.chans = ($urandom_range(0, 4) == 0) ? CC_W'($urandom_range(0, 7))
                                          : CC_W'($urandom_range(1, NUM_CH));
    case ($urandom_range(0, 9))
      0: begin
        s.in_rate = RATE_W'($urandom);
        s.out_rate = s.in_rate;
      end
      1, 2, 3: begin
        s.in_rate = RATE_W'($urandom_range(1, 9));
        s.out_rate = RATE_W'($urandom_range(1, 9));
      end
      4, 5: begin
        s.in_rate = RATE_W'($urandom_range(8000, 192000));
        s.out_rate = RATE_W'($urandom_range(8000, 192000));
      end
      6: begin
        s.in_rate = RATE_W'($urandom_range(1, 100));
        s.out_rate = RATE_W'($urandom);
      end
      7: begin
        s.in_rate = RATE_W'($urandom);
        s.out_rate = RATE_W'($urandom_range(1, 100));
      end
      8: begin
        s.in_rate = RATE_W'($urandom);
        s.out_rate = RATE_W'($urandom);
      end
      default: begin
        s.in_rate = edge_rate();
        s.out_rate = edge_rate();
      end
    endcase
    return s;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(0, 19))
        0: f[c] = '0;
        1: f[c] = '1;
        default: f[c] = SAMPLE_W'($urandom);
      endcase
    end
    return f;
  endfunction

  function automatic frame_t pattern_frame(input int k);
    case (k % 5)
      0: return '1;
      1: return '0;
      2: return {32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA};
      3: return {32'h7FFFFFFE, 32'hFF00FF00, 32'h00FF00FF, 32'h80000001};
      default: return random_frame();
    endcase
  endfunction

  // Raises a request after an optional gap and holds it until it is taken.
  task automatic send_frame(input frame_t f, input logic last);
    int gap;
    gap = sender_idles ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_a <= f[0];
    in_sample_b <= f[1];
    in_sample_c <= f[2];
    in_sample_d <= f[3];
    in_last_frame <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  // Leaves psel and penable high; the caller returns the bus to idle after the last write.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_setting(input conv_setting_t s);
    write_reg(REG_IN_BITS, DATA_W'(s.in_bits));
    write_reg(REG_OUT_BITS, DATA_W'(s.out_bits));
    write_reg(REG_CHANNELS, DATA_W'(s.chans));
    write_reg(REG_IN_RATE, DATA_W'(s.in_rate));
    write_reg(REG_OUT_RATE, DATA_W'(s.out_rate));
    psel <= 1'b0;
    penable <= 1'b0;
    settings_applied++;
  endtask

  // A frame can cause no output, so the block may still be busy once nothing is owed.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_stream(input int n, input bit close_stream);
    for (int i = 0; i < n; i++) begin
      send_frame(pattern_frame(i), close_stream && (i == n - 1));
    end
  endtask

  // Streams of random length, mostly closed by last_frame; some marks are flipped.
  task automatic run_random_phase(input int n);
    int   stream_left;
    logic last;
    stream_left = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      last = (stream_left == 1);
      if ($urandom_range(0, 9) == 0) last = !last;
      send_frame(random_frame(), last);
      stream_left--;
      if (last || stream_left <= 0) stream_left = $urandom_range(1, 10);
    end
  endtask

  task automatic directed_phase(input conv_setting_t s, input int n);
    settle();
    apply_setting(s);
    run_stream(n, 1'b1);
  endtask

  initial begin
    int directed_count;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_a <= '0;
    in_sample_b <= '0;
    in_sample_c <= '0;
    in_sample_d <= '0;
    in_last_frame <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: equal rates, 16-bit samples, two channels.
    run_stream(3, 1'b1);
    // Huge upsampling ratio: every frame clips at the repeat limit.
    directed_phase(make_setting(32, 8, 4, 1, 16777215), 2);
    // Exactly the repeat limit, output depth clamped to the input depth.
    directed_phase(make_setting(24, 63, 3, 1, 64), 2);
    // Zero rates, zero depths and zero channels.
    directed_phase(make_setting(0, 0, 0, 0, 0), 2);
    // Plain downsampling with oversized depth and channel count.
    directed_phase(make_setting(63, 17, 7, 3, 2), 5);
    // Extreme downsampling: the held frame is dropped at the end of the stream.
    directed_phase(make_setting(8, 32, 5, 16777215, 1), 3);
    // Leave a frame held and a phase that becomes stale under the next rates.
    run_stream(3, 1'b0);
    // Upsampling after a rate change; the closing frame produces nothing.
    directed_phase(make_setting(32, 32, 4, 3, 4), 2);
    directed_count = frames_sent;

    while (frames_sent < directed_count + RANDOM_ITEMS) begin
      settle();
      apply_setting(random_setting());
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      run_random_phase($urandom_range(6, 24));
    end

    settle();
    $display("Sent %0d input frames (%0d directed) under %0d register settings.",
             frames_sent, directed_count, settings_applied);
    $display("Compared %0d output frames against the prediction.", results_checked);
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
